[rtl/mpp_pkg.sv]
// Shared types and constants for the motion projection profile block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package mpp_pkg;

    // Frame geometry and counter sizing
    localparam int MAX_COLS   = 1024;
    localparam int MAX_ROWS   = 1024;
    localparam int COUNT_BITS = 32;

    localparam int COL_BITS = $clog2(MAX_COLS);
    localparam int ROW_BITS = $clog2(MAX_ROWS);
    localparam int MAX_DIM  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int IDX_BITS = $clog2(MAX_DIM);

    localparam int FRAME_DEPTH     = MAX_ROWS * MAX_COLS;
    localparam int FRAME_ADDR_BITS = ROW_BITS + COL_BITS;

    // Field and register widths
    localparam int PIX_BITS = 8;
    localparam int THR_BITS = 8;
    localparam int DIM_BITS = 11;
    localparam int CFG_BITS = DIM_BITS;

    // Register reset values
    localparam logic [THR_BITS-1:0] THRESHOLD_RESET  = THR_BITS'(19);
    localparam logic [DIM_BITS-1:0] FRAME_COLS_RESET = DIM_BITS'(640);
    localparam logic [DIM_BITS-1:0] FRAME_ROWS_RESET = DIM_BITS'(480);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Between-block queue
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_ROW_THRESHOLD = 2'd0,
        CFG_COL_THRESHOLD = 2'd1,
        CFG_FRAME_COLS    = 2'd2,
        CFG_FRAME_ROWS    = 2'd3
    } mpp_cfg_index_t;

    // Configuration as seen by the datapath, dimensions already clamped
    typedef struct packed {
        logic [THR_BITS-1:0] row_thr;
        logic [THR_BITS-1:0] col_thr;
        logic [DIM_BITS-1:0] cols;
        logic [DIM_BITS-1:0] rows;
    } mpp_cfg_t;

    // One classified pixel on its way from front to back
    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                first;    // pixel of a first frame: store only
        logic                report;   // last pixel of a reported frame
        logic                restart;  // first pixel of a new video
    } mpp_op_t;

endpackage

[rtl/mpp_if.sv]
// Stream interfaces for the pixel input and the peak result output.
// Depends on mpp_pkg for field widths.
`timescale 1ns / 1ps

interface mpp_pixel_if import mpp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [PIX_BITS-1:0] pixel;
    logic                video_start;

    modport source (output valid, output pixel, output video_start, input ready);
    modport sink   (input valid, input pixel, input video_start, output ready);
endinterface

interface mpp_peak_if import mpp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [ROW_BITS-1:0]   peak_row;
    logic [COL_BITS-1:0]   peak_col;
    logic [COUNT_BITS-1:0] peak_row_count;
    logic [COUNT_BITS-1:0] peak_col_count;
    logic                  any_motion;

    modport source (output valid, output peak_row, output peak_col,
                    output peak_row_count, output peak_col_count,
                    output any_motion, input ready);
    modport sink   (input valid, input peak_row, input peak_col,
                    input peak_row_count, input peak_col_count,
                    input any_motion, output ready);
endinterface

[rtl/mpp_front.sv]
// Front end: accepts pixels, tracks raster position and frame phase,
// and pushes one classified op per pixel into the queue. Uses mpp_pkg, mpp_if.
`timescale 1ns / 1ps

module mpp_front import mpp_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  mpp_cfg_t    cfg,
    mpp_pixel_if.sink   pixels,
    input  logic        full,
    output logic        push,
    output mpp_op_t     push_op
);

    logic [ROW_BITS-1:0] row_pos_reg, row_pos_next;
    logic [COL_BITS-1:0] col_pos_reg, col_pos_next;
    logic                first_reg, first_next;

    logic [ROW_BITS-1:0] cur_row;
    logic [COL_BITS-1:0] cur_col;
    logic                cur_first;
    logic                end_row;
    logic                end_frame;

    assign pixels.ready = !full;
    assign push         = pixels.valid && !full;

    // Position of this pixel; a video start restarts at the origin
    always_comb
    begin
        cur_row   = pixels.video_start ? '0 : row_pos_reg;
        cur_col   = pixels.video_start ? '0 : col_pos_reg;
        cur_first = pixels.video_start ? 1'b1 : first_reg;
        end_row   = (DIM_BITS'(cur_col) + DIM_BITS'(1)) >= cfg.cols;
        end_frame = end_row && ((DIM_BITS'(cur_row) + DIM_BITS'(1)) >= cfg.rows);
    end

    // Classified op
    always_comb
    begin
        push_op.pixel   = pixels.pixel;
        push_op.row     = cur_row;
        push_op.col     = cur_col;
        push_op.first   = cur_first;
        push_op.report  = end_frame && !cur_first;
        push_op.restart = pixels.video_start;
    end

    // Raster advance on each transfer
    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        first_next   = first_reg;
        if (push)
        begin
            if (end_row)
            begin
                col_pos_next = '0;
                row_pos_next = end_frame ? '0 : cur_row + ROW_BITS'(1);
            end
            else
            begin
                col_pos_next = cur_col + COL_BITS'(1);
                row_pos_next = cur_row;
            end
            first_next = end_frame ? 1'b0 : cur_first;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            first_reg   <= 1'b1;
        end
        else
        begin
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            first_reg   <= first_next;
        end
    end

endmodule

[rtl/mpp_queue.sv]
// Short FIFO of classified ops between the front end and the back end.
// Uses mpp_pkg for the op type and depth.
`timescale 1ns / 1ps

module mpp_queue import mpp_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  mpp_op_t push_op,
    output logic    full,
    output logic    head_valid,
    output mpp_op_t head_op,
    input  logic    pop
);

    mpp_op_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_BITS:0]   count_reg, count_next;

    assign full       = count_reg == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_op    = slot_reg[rd_ptr_reg];

    // Occupancy
    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + (QUEUE_PTR_BITS + 1)'(1);
            2'b01:   count_next = count_reg - (QUEUE_PTR_BITS + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

[rtl/mpp_back.sv]
// Back end: frame store, row/column count memories with saturating
// read-modify-write, running peak tracking, clear and rescan sweeps, result
// register. Uses mpp_pkg and mpp_if.
`timescale 1ns / 1ps

module mpp_back import mpp_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  mpp_cfg_t  cfg,
    input  logic      scan_start,
    input  logic      head_valid,
    input  mpp_op_t   head_op,
    output logic      pop,
    mpp_peak_if.source peaks
);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_CLEAR = 3'b010,
        ST_SCAN  = 3'b100
    } mpp_back_state_t;

    mpp_back_state_t state_reg, state_next;

    // Storage
    logic [PIX_BITS-1:0]   frame_mem [FRAME_DEPTH];
    logic [COUNT_BITS-1:0] row_mem [MAX_ROWS];
    logic [COUNT_BITS-1:0] col_mem [MAX_COLS];

    // Sweep counters
    logic [IDX_BITS-1:0] sweep_idx_reg, sweep_idx_next;
    logic                scan_rd_v_reg, scan_rd_v_next;
    logic [IDX_BITS-1:0] scan_idx_reg, scan_idx_next;

    // Read data and second stage
    logic [PIX_BITS-1:0]   prev_pix_reg;
    logic [COUNT_BITS-1:0] row_rd_reg, col_rd_reg;
    logic                  s1_valid_reg;
    mpp_op_t               s1_op_reg;

    // Write bypass: the write that landed at the same edge as the read
    logic                  row_byp_v_reg, col_byp_v_reg;
    logic [ROW_BITS-1:0]   row_byp_addr_reg;
    logic [COL_BITS-1:0]   col_byp_addr_reg;
    logic [COUNT_BITS-1:0] row_byp_data_reg, col_byp_data_reg;

    // Running peaks
    logic [ROW_BITS-1:0]   best_row_idx_reg, best_row_idx_next;
    logic [COL_BITS-1:0]   best_col_idx_reg, best_col_idx_next;
    logic [COUNT_BITS-1:0] best_row_val_reg, best_row_val_next;
    logic [COUNT_BITS-1:0] best_col_val_reg, best_col_val_next;

    // Result register
    logic                  out_valid_reg, out_valid_next;
    logic [ROW_BITS-1:0]   out_row_reg;
    logic [COL_BITS-1:0]   out_col_reg;
    logic [COUNT_BITS-1:0] out_row_cnt_reg, out_col_cnt_reg;
    logic                  out_any_reg;

    logic                  clear_start;
    logic                  scan_go;
    logic                  counts_free;
    logic                  out_free;

    logic [FRAME_ADDR_BITS-1:0] fs_addr;
    logic [ROW_BITS-1:0]   row_rd_addr, row_wr_addr;
    logic [COL_BITS-1:0]   col_rd_addr, col_wr_addr;
    logic                  row_we, col_we;
    logic [COUNT_BITS-1:0] row_wr_data, col_wr_data;

    logic [PIX_BITS-1:0]   pix_diff;
    logic                  row_hit, col_hit;
    logic [COUNT_BITS-1:0] row_old, col_old, row_new, col_new;
    logic                  row_better, col_better;
    logic [ROW_BITS-1:0]   row_upd_idx;
    logic [COL_BITS-1:0]   col_upd_idx;
    logic [COUNT_BITS-1:0] row_upd_val, col_upd_val;
    logic                  scan_row_better, scan_col_better;

    // Issue control: counts are touched only in RUN, results need room
    assign counts_free = (state_reg == ST_RUN) && !scan_start;
    assign out_free    = !(s1_valid_reg && s1_op_reg.report)
                         && (!out_valid_reg || peaks.ready);
    assign pop         = head_valid && (head_op.first || counts_free)
                         && (!head_op.report || out_free);
    assign clear_start = pop && head_op.restart;
    assign scan_go     = scan_start && !clear_start && (state_reg != ST_CLEAR);

    // Sweep sequencer
    always_comb
    begin
        state_next     = state_reg;
        sweep_idx_next = sweep_idx_reg;
        scan_rd_v_next = 1'b0;
        scan_idx_next  = scan_idx_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (clear_start)
                begin
                    state_next     = ST_CLEAR;
                    sweep_idx_next = '0;
                end
                else if (scan_go)
                begin
                    state_next     = ST_SCAN;
                    sweep_idx_next = '0;
                end
            end
            ST_CLEAR:
            begin
                if (clear_start)
                begin
                    sweep_idx_next = '0;
                end
                else if (sweep_idx_reg == IDX_BITS'(MAX_DIM - 1))
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    sweep_idx_next = sweep_idx_reg + IDX_BITS'(1);
                end
            end
            ST_SCAN:
            begin
                if (clear_start)
                begin
                    state_next     = ST_CLEAR;
                    sweep_idx_next = '0;
                end
                else if (scan_go)
                begin
                    sweep_idx_next = '0;
                end
                else
                begin
                    scan_rd_v_next = 1'b1;
                    scan_idx_next  = sweep_idx_reg;
                    if (sweep_idx_reg == IDX_BITS'(MAX_DIM - 1))
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        sweep_idx_next = sweep_idx_reg + IDX_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Frame store: read old pixel, write new one, same address
    assign fs_addr = {head_op.row, head_op.col};

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            prev_pix_reg       <= frame_mem[fs_addr];
            frame_mem[fs_addr] <= head_op.pixel;
        end
    end

    // Count memory ports
    always_comb
    begin
        row_rd_addr = (state_reg == ST_SCAN) ? sweep_idx_reg[ROW_BITS-1:0] : head_op.row;
        col_rd_addr = (state_reg == ST_SCAN) ? sweep_idx_reg[COL_BITS-1:0] : head_op.col;
        if (state_reg == ST_CLEAR)
        begin
            row_we      = 1'b1;
            col_we      = 1'b1;
            row_wr_addr = sweep_idx_reg[ROW_BITS-1:0];
            col_wr_addr = sweep_idx_reg[COL_BITS-1:0];
            row_wr_data = '0;
            col_wr_data = '0;
        end
        else
        begin
            row_we      = row_hit;
            col_we      = col_hit;
            row_wr_addr = s1_op_reg.row;
            col_wr_addr = s1_op_reg.col;
            row_wr_data = row_new;
            col_wr_data = col_new;
        end
    end

    always_ff @(posedge clk)
    begin
        row_rd_reg <= row_mem[row_rd_addr];
        if (row_we)
        begin
            row_mem[row_wr_addr] <= row_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        col_rd_reg <= col_mem[col_rd_addr];
        if (col_we)
        begin
            col_mem[col_wr_addr] <= col_wr_data;
        end
    end

    // Second stage: difference, threshold, saturating increment
    always_comb
    begin
        pix_diff = (s1_op_reg.pixel > prev_pix_reg) ? s1_op_reg.pixel - prev_pix_reg
                                                     : prev_pix_reg - s1_op_reg.pixel;
        row_hit  = s1_valid_reg && !s1_op_reg.first && (pix_diff > cfg.row_thr);
        col_hit  = s1_valid_reg && !s1_op_reg.first && (pix_diff > cfg.col_thr);
        row_old  = (row_byp_v_reg && row_byp_addr_reg == s1_op_reg.row)
                   ? row_byp_data_reg : row_rd_reg;
        col_old  = (col_byp_v_reg && col_byp_addr_reg == s1_op_reg.col)
                   ? col_byp_data_reg : col_rd_reg;
        row_new  = (row_old == COUNT_MAX) ? row_old : row_old + COUNT_BITS'(1);
        col_new  = (col_old == COUNT_MAX) ? col_old : col_old + COUNT_BITS'(1);
    end

    // Peak update: counts only grow, so the peak moves on a raise or a tie
    // at a lower index, and only for entries inside the frame in use
    always_comb
    begin
        row_better = row_hit && (DIM_BITS'(s1_op_reg.row) < cfg.rows)
                     && ((row_new > best_row_val_reg)
                         || (row_new == best_row_val_reg && s1_op_reg.row < best_row_idx_reg));
        col_better = col_hit && (DIM_BITS'(s1_op_reg.col) < cfg.cols)
                     && ((col_new > best_col_val_reg)
                         || (col_new == best_col_val_reg && s1_op_reg.col < best_col_idx_reg));
        row_upd_idx = row_better ? s1_op_reg.row : best_row_idx_reg;
        row_upd_val = row_better ? row_new : best_row_val_reg;
        col_upd_idx = col_better ? s1_op_reg.col : best_col_idx_reg;
        col_upd_val = col_better ? col_new : best_col_val_reg;
    end

    // Rescan compare, lowest index wins on ties
    always_comb
    begin
        scan_row_better = scan_rd_v_reg && (DIM_BITS'(scan_idx_reg) < cfg.rows)
                          && (row_rd_reg > best_row_val_reg);
        scan_col_better = scan_rd_v_reg && (DIM_BITS'(scan_idx_reg) < cfg.cols)
                          && (col_rd_reg > best_col_val_reg);
    end

    always_comb
    begin
        best_row_idx_next = row_upd_idx;
        best_row_val_next = row_upd_val;
        best_col_idx_next = col_upd_idx;
        best_col_val_next = col_upd_val;
        if (clear_start || scan_go)
        begin
            best_row_idx_next = '0;
            best_row_val_next = '0;
            best_col_idx_next = '0;
            best_col_val_next = '0;
        end
        else
        begin
            if (scan_row_better)
            begin
                best_row_idx_next = scan_idx_reg[ROW_BITS-1:0];
                best_row_val_next = row_rd_reg;
            end
            if (scan_col_better)
            begin
                best_col_idx_next = scan_idx_reg[COL_BITS-1:0];
                best_col_val_next = col_rd_reg;
            end
        end
    end

    // Result handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_valid_reg && s1_op_reg.report)
        begin
            out_valid_next = 1'b1;
        end
        else if (peaks.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign peaks.valid          = out_valid_reg;
    assign peaks.peak_row       = out_row_reg;
    assign peaks.peak_col       = out_col_reg;
    assign peaks.peak_row_count = out_row_cnt_reg;
    assign peaks.peak_col_count = out_col_cnt_reg;
    assign peaks.any_motion     = out_any_reg;

    // Payload registers
    always_ff @(posedge clk)
    begin
        s1_op_reg        <= head_op;
        row_byp_addr_reg <= row_wr_addr;
        row_byp_data_reg <= row_wr_data;
        col_byp_addr_reg <= col_wr_addr;
        col_byp_data_reg <= col_wr_data;
        if (s1_valid_reg && s1_op_reg.report)
        begin
            out_row_reg     <= row_upd_idx;
            out_col_reg     <= col_upd_idx;
            out_row_cnt_reg <= row_upd_val;
            out_col_cnt_reg <= col_upd_val;
            out_any_reg     <= (row_upd_val != '0) || (col_upd_val != '0);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            sweep_idx_reg    <= '0;
            scan_rd_v_reg    <= 1'b0;
            scan_idx_reg     <= '0;
            s1_valid_reg     <= 1'b0;
            row_byp_v_reg    <= 1'b0;
            col_byp_v_reg    <= 1'b0;
            best_row_idx_reg <= '0;
            best_row_val_reg <= '0;
            best_col_idx_reg <= '0;
            best_col_val_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_idx_reg    <= sweep_idx_next;
            scan_rd_v_reg    <= scan_rd_v_next;
            scan_idx_reg     <= scan_idx_next;
            s1_valid_reg     <= pop;
            row_byp_v_reg    <= row_hit && (state_reg != ST_CLEAR);
            col_byp_v_reg    <= col_hit && (state_reg != ST_CLEAR);
            best_row_idx_reg <= best_row_idx_next;
            best_row_val_reg <= best_row_val_next;
            best_col_idx_reg <= best_col_idx_next;
            best_col_val_reg <= best_col_val_next;
            out_valid_reg    <= out_valid_next;
        end
    end

endmodule

[rtl/motion_projection_profile.sv]
// Throughput: one pixel per cycle unless a sweep or result back-pressure stalls it;
// each pixel does one frame-store and one row and one column count read-modify-write
// in the back end, bypassed so that no pixel waits. Reset: a clear of the count memories
// follows reset and every video start; a write of frame_cols or frame_rows starts a
// peak rescan. First-frame pixels flow through both sweeps; later pixels wait for them.
// The frame store is not cleared.
`timescale 1ns / 1ps

module motion_projection_profile import mpp_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    mpp_pixel_if.sink           pixels,
    mpp_peak_if.source          peaks
);

    logic [THR_BITS-1:0] row_thr_reg, col_thr_reg;
    logic [DIM_BITS-1:0] frame_cols_reg, frame_rows_reg;

    mpp_cfg_t  cfg;
    logic      scan_start;
    logic      push;
    mpp_op_t   push_op;
    logic      full;
    logic      head_valid;
    mpp_op_t   head_op;
    logic      pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_thr_reg    <= THRESHOLD_RESET;
            col_thr_reg    <= THRESHOLD_RESET;
            frame_cols_reg <= FRAME_COLS_RESET;
            frame_rows_reg <= FRAME_ROWS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (mpp_cfg_index_t'(cfg_index))
                CFG_ROW_THRESHOLD: row_thr_reg    <= cfg_data[THR_BITS-1:0];
                CFG_COL_THRESHOLD: col_thr_reg    <= cfg_data[THR_BITS-1:0];
                CFG_FRAME_COLS:    frame_cols_reg <= cfg_data[DIM_BITS-1:0];
                CFG_FRAME_ROWS:    frame_rows_reg <= cfg_data[DIM_BITS-1:0];
                default:           row_thr_reg    <= row_thr_reg;
            endcase
        end
    end

    // New frame size changes which entries count toward the peak
    assign scan_start = cfg_we && ((mpp_cfg_index_t'(cfg_index) == CFG_FRAME_COLS)
                                   || (mpp_cfg_index_t'(cfg_index) == CFG_FRAME_ROWS));

    // Clamp dimensions to 1..max
    always_comb
    begin
        cfg.row_thr = row_thr_reg;
        cfg.col_thr = col_thr_reg;
        if (frame_cols_reg == '0)
            cfg.cols = DIM_BITS'(1);
        else if (frame_cols_reg > DIM_BITS'(MAX_COLS))
            cfg.cols = DIM_BITS'(MAX_COLS);
        else
            cfg.cols = frame_cols_reg;
        if (frame_rows_reg == '0)
            cfg.rows = DIM_BITS'(1);
        else if (frame_rows_reg > DIM_BITS'(MAX_ROWS))
            cfg.rows = DIM_BITS'(MAX_ROWS);
        else
            cfg.rows = frame_rows_reg;
    end

    mpp_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .pixels  (pixels),
        .full    (full),
        .push    (push),
        .push_op (push_op)
    );

    mpp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .full       (full),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop)
    );

    mpp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .scan_start (scan_start),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .peaks      (peaks)
    );

endmodule

[test/mpp_checker.sv]
// Scoreboard for the motion projection profile block: tracks config writes and pixel
// transfers, predicts each peak result and compares it field by field.
// Depends on mpp_pkg and the stream interfaces in mpp_if.sv.
`timescale 1ns / 1ps

module mpp_checker import mpp_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    mpp_pixel_if                pixels,
    mpp_peak_if                 peaks,
    output int                  fail_count,
    output int                  pending
);

    typedef struct packed {
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic [COUNT_BITS-1:0] row_count;
        logic [COUNT_BITS-1:0] col_count;
        logic                  any_motion;
    } peak_t;

    // Predicted peaks, oldest first
    peak_t peak_queue[$];

    // Shadow of the block's state
    logic [PIX_BITS-1:0]   frame_store [0:FRAME_DEPTH-1];
    logic [COUNT_BITS-1:0] row_motion [0:MAX_ROWS-1];
    logic [COUNT_BITS-1:0] col_motion [0:MAX_COLS-1];
    logic [THR_BITS-1:0]   row_thr;
    logic [THR_BITS-1:0]   col_thr;
    logic [DIM_BITS-1:0]   cols_cfg;
    logic [DIM_BITS-1:0]   rows_cfg;
    int unsigned           cur_row;
    int unsigned           cur_col;
    bit                    first_frame;

    function automatic int unsigned clamp_dim(logic [DIM_BITS-1:0] v, int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    task automatic report_error(input string msg);
        fail_count++;
        $display("%0t: %s", $time, msg);
    endtask

    task automatic clear_motion();
        int i;
        for (i = 0; i < MAX_ROWS; i++)
            row_motion[i] = '0;
        for (i = 0; i < MAX_COLS; i++)
            col_motion[i] = '0;
    endtask

    task automatic restart_model();
        row_thr     = THRESHOLD_RESET;
        col_thr     = THRESHOLD_RESET;
        cols_cfg    = FRAME_COLS_RESET;
        rows_cfg    = FRAME_ROWS_RESET;
        cur_row     = 0;
        cur_col     = 0;
        first_frame = 1'b1;
        clear_motion();
        peak_queue.delete();
        pending     = 0;
    endtask

    // One pixel: difference against the stored frame, count update, peak search at
    // the end of every frame that follows the first one of a video
    task automatic predict_pixel(input logic [PIX_BITS-1:0] pix, input logic vs);
        int unsigned         nc;
        int unsigned         nr;
        int unsigned         addr;
        int unsigned         i;
        logic [PIX_BITS-1:0] prev;
        logic [PIX_BITS-1:0] diff;
        bit                  frame_done;
        peak_t               pk;

        nc = clamp_dim(cols_cfg, MAX_COLS);
        nr = clamp_dim(rows_cfg, MAX_ROWS);
        frame_done = 1'b0;

        if (vs) begin
            clear_motion();
            cur_row     = 0;
            cur_col     = 0;
            first_frame = 1'b1;
        end

        addr = cur_row * MAX_COLS + cur_col;
        if (!first_frame) begin
            prev = frame_store[addr];
            diff = (pix > prev) ? pix - prev : prev - pix;
            if (diff > row_thr && row_motion[cur_row] != COUNT_MAX)
                row_motion[cur_row] = row_motion[cur_row] + 1'b1;
            if (diff > col_thr && col_motion[cur_col] != COUNT_MAX)
                col_motion[cur_col] = col_motion[cur_col] + 1'b1;
        end
        frame_store[addr] = pix;

        // raster advance; a position past a shrunken limit wraps here
        if (cur_col + 1 >= nc) begin
            cur_col = 0;
            if (cur_row + 1 >= nr) begin
                cur_row    = 0;
                frame_done = 1'b1;
            end
            else
                cur_row = cur_row + 1;
        end
        else
            cur_col = cur_col + 1;

        if (frame_done) begin
            if (first_frame)
                first_frame = 1'b0;
            else begin
                pk = '0;
                // strict compare keeps the lowest index on ties
                for (i = 0; i < nr; i++) begin
                    if (row_motion[i] > pk.row_count) begin
                        pk.row_count = row_motion[i];
                        pk.row       = ROW_BITS'(i);
                    end
                end
                for (i = 0; i < nc; i++) begin
                    if (col_motion[i] > pk.col_count) begin
                        pk.col_count = col_motion[i];
                        pk.col       = COL_BITS'(i);
                    end
                end
                pk.any_motion = (pk.row_count != 0) || (pk.col_count != 0);
                peak_queue.push_back(pk);
            end
        end
    endtask

    initial begin
        fail_count = 0;
        restart_model();
    end

    // Sample config writes and both channels at the rising edge; a pixel transferred
    // at the same edge as a register write still sees the old register value
    always @(posedge clk or negedge rst_n) begin : monitor
        peak_t exp_pk;
        if (!rst_n)
            restart_model();
        else begin
            if (peaks.valid && peaks.ready) begin
                if (peak_queue.size() == 0)
                    report_error("peak result transferred while none was expected");
                else begin
                    exp_pk = peak_queue.pop_front();
                    if (peaks.peak_row !== exp_pk.row)
                        report_error($sformatf("peak_row: expected %0d, got %0d",
                                               exp_pk.row, peaks.peak_row));
                    if (peaks.peak_col !== exp_pk.col)
                        report_error($sformatf("peak_col: expected %0d, got %0d",
                                               exp_pk.col, peaks.peak_col));
                    if (peaks.peak_row_count !== exp_pk.row_count)
                        report_error($sformatf("peak_row_count: expected %0d, got %0d",
                                               exp_pk.row_count, peaks.peak_row_count));
                    if (peaks.peak_col_count !== exp_pk.col_count)
                        report_error($sformatf("peak_col_count: expected %0d, got %0d",
                                               exp_pk.col_count, peaks.peak_col_count));
                    if (peaks.any_motion !== exp_pk.any_motion)
                        report_error($sformatf("any_motion: expected %0d, got %0d",
                                               exp_pk.any_motion, peaks.any_motion));
                end
            end

            if (pixels.valid && pixels.ready)
                predict_pixel(pixels.pixel, pixels.video_start);

            if (cfg_we) begin
                case (mpp_cfg_index_t'(cfg_index))
                    CFG_ROW_THRESHOLD: row_thr  = cfg_data[THR_BITS-1:0];
                    CFG_COL_THRESHOLD: col_thr  = cfg_data[THR_BITS-1:0];
                    CFG_FRAME_COLS:    cols_cfg = cfg_data;
                    CFG_FRAME_ROWS:    rows_cfg = cfg_data;
                    default: ;
                endcase
            end

            pending = peak_queue.size();
        end
    end

endmodule

[test/tb_motion_projection_profile.sv]
// Top of the motion projection profile testbench: clock, reset, register writes,
// pixel stimulus with random gaps, result back-pressure and the verdict.
// Depends on mpp_pkg, mpp_if.sv, the block itself and mpp_checker.
`timescale 1ns / 1ps

module tb_motion_projection_profile;
    import mpp_pkg::*;

    localparam int CYCLE_LIMIT      = 1000000;
    localparam int RANDOM_ITEMS     = 700;
    // longer than a full count-memory sweep, so nothing is left in flight
    localparam int SETTLE_CYCLES    = 1100;
    localparam int DRAIN_CYCLES     = 64;
    localparam int LONG_HOLD_CYCLES = 3000;
    localparam int BURST_ITEMS      = 120;
    localparam int TALL_ROWS        = 300;
    localparam int QUIET_SPAN       = 200;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [CFG_BITS-1:0] cfg_data;

    mpp_pixel_if pix_ch ();
    mpp_peak_if  peak_ch ();

    int fail_count;
    int pending;
    int cycle_count = 0;

    bit idle_on;
    bit hold_request;

    // Stimulus-side view of the raster position, used to keep every read of the
    // frame store on an entry that has been written
    bit                  written_map [0:FRAME_DEPTH-1];
    int unsigned         gen_row;
    int unsigned         gen_col;
    bit                  gen_first;
    logic [DIM_BITS-1:0] gen_cols;
    logic [DIM_BITS-1:0] gen_rows;

    motion_projection_profile u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pix_ch),
        .peaks     (peak_ch)
    );

    mpp_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixels     (pix_ch),
        .peaks      (peak_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Hang guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("motion_projection_profile test failed");
            $finish;
        end
    end

    function automatic int unsigned fit_dim(logic [DIM_BITS-1:0] v, int unsigned maxv);
        if (v == 0)
            return 1;
        if (v > maxv)
            return maxv;
        return 32'(v);
    endfunction

    function automatic int pick_threshold();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 255;
            2:       return $urandom_range(0, 2047);   // upper bits are dropped
            default: return $urandom_range(0, 60);
        endcase
    endfunction

    function automatic logic [PIX_BITS-1:0] pick_pixel(int base, int spread);
        return PIX_BITS'(base + $urandom_range(0, spread));
    endfunction

    task automatic write_reg(input mpp_cfg_index_t idx, input int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DIM_BITS'(value);
        if (idx == CFG_FRAME_COLS)
            gen_cols = DIM_BITS'(value);
        else if (idx == CFG_FRAME_ROWS)
            gen_rows = DIM_BITS'(value);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Drop valid and hold until every predicted peak has been transferred
    task automatic wait_results();
        @(negedge clk);
        pix_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic wait_idle();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One pixel transfer; a video start is forced where the next read would hit an
    // unwritten frame-store entry
    task automatic send_pixel(input logic [PIX_BITS-1:0] pix, input logic start_in);
        logic        start;
        int          gap;
        int unsigned cols_now;
        int unsigned rows_now;

        start = start_in;
        if (!start && !gen_first && !written_map[gen_row * MAX_COLS + gen_col])
            start = 1'b1;
        if (start)
        begin
            gen_row   = 0;
            gen_col   = 0;
            gen_first = 1'b1;
        end
        written_map[gen_row * MAX_COLS + gen_col] = 1'b1;

        cols_now = fit_dim(gen_cols, MAX_COLS);
        rows_now = fit_dim(gen_rows, MAX_ROWS);
        if (gen_col + 1 >= cols_now)
        begin
            gen_col = 0;
            if (gen_row + 1 >= rows_now)
            begin
                gen_row   = 0;
                gen_first = 1'b0;
            end
            else
                gen_row = gen_row + 1;
        end
        else
            gen_col = gen_col + 1;

        gap = idle_on ? $urandom_range(0, 15) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel       <= pix;
        pix_ch.video_start <= start;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
    endtask

    // Result side: random stall per result, plus one long hold on request
    initial
    begin : result_sink
        int stall;
        peak_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                peak_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            stall = idle_on ? $urandom_range(0, 15) : 0;
            if (stall > 0)
            begin
                peak_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            peak_ch.ready <= 1'b1;
            @(posedge clk);
            while (!peak_ch.valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int   i;
        int   n;
        int   spread;
        int   pause_at;
        int   base;
        int   random_sent;
        bit   fresh;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_ROW_THRESHOLD;
        cfg_data           = '0;
        pix_ch.valid       = 1'b0;
        pix_ch.pixel       = '0;
        pix_ch.video_start = 1'b0;
        hold_request       = 1'b0;
        idle_on            = 1'b1;
        gen_row            = 0;
        gen_col            = 0;
        gen_first          = 1'b1;
        gen_cols           = FRAME_COLS_RESET;
        gen_rows           = FRAME_ROWS_RESET;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: 3x2 frames, extreme thresholds, full-scale differences
        write_reg(CFG_ROW_THRESHOLD, 0);
        write_reg(CFG_COL_THRESHOLD, 255);
        write_reg(CFG_FRAME_COLS, 3);
        write_reg(CFG_FRAME_ROWS, 2);
        for (i = 0; i < 6; i++)
            send_pixel((i % 2) ? 8'hFF : 8'h00, i == 0);
        for (i = 0; i < 6; i++)
            send_pixel((i % 2) ? 8'h00 : 8'hFF, 1'b0);
        // start of a frame with no change, then narrow the frame mid-row
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        wait_idle();
        write_reg(CFG_FRAME_COLS, 2);
        write_reg(CFG_ROW_THRESHOLD, 255);
        write_reg(CFG_COL_THRESHOLD, 0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'hFF, 1'b0);
        // zero dimensions act as one: every pixel ends a frame
        wait_idle();
        write_reg(CFG_FRAME_COLS, 0);
        write_reg(CFG_FRAME_ROWS, 1);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h80, 1'b0);
        // video start in mid-stream clears the counts
        send_pixel(8'h07, 1'b1);
        send_pixel(8'h07, 1'b0);

        // Random phases: small frames, varied motion, stray video starts
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_ROW_THRESHOLD, pick_threshold());
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_COL_THRESHOLD, pick_threshold());
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_FRAME_COLS,
                          ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
            if ($urandom_range(0, 2) == 0)
                write_reg(CFG_FRAME_ROWS,
                          ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4));
            idle_on = ($urandom_range(0, 3) != 0);
            base    = $urandom_range(0, 255);
            case ($urandom_range(0, 3))
                0:       spread = 0;
                1:       spread = 8;
                2:       spread = 48;
                default: spread = 255;
            endcase
            n        = $urandom_range(1, 60);
            fresh    = ($urandom_range(0, 1) == 1);
            pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
            for (i = 0; i < n; i++)
            begin
                if (i == pause_at)
                    wait_results();
                send_pixel(pick_pixel(base, spread),
                           (i == 0 && fresh) || ($urandom_range(0, 49) == 0));
            end
            random_sent += n;
        end

        // Back-pressure: two-pixel frames while the result side holds off
        wait_idle();
        write_reg(CFG_FRAME_COLS, 2);
        write_reg(CFG_FRAME_ROWS, 1);
        idle_on      = 1'b0;
        hold_request = 1'b1;
        base         = $urandom_range(0, 255);
        for (i = 0; i < BURST_ITEMS; i++)
            send_pixel(pick_pixel(base, 255), i == 0);

        // Tall frame: one column, many rows; motion only deep in the frame
        wait_idle();
        write_reg(CFG_ROW_THRESHOLD, int'(THRESHOLD_RESET));
        write_reg(CFG_COL_THRESHOLD, int'(THRESHOLD_RESET));
        write_reg(CFG_FRAME_COLS, 1);
        write_reg(CFG_FRAME_ROWS, TALL_ROWS);
        idle_on = 1'b1;
        base    = $urandom_range(0, 255);
        for (i = 0; i < 2 * TALL_ROWS; i++)
            send_pixel((i >= TALL_ROWS && (i % TALL_ROWS) >= QUIET_SPAN) ?
                       pick_pixel(base, 255) : PIX_BITS'(base), i == 0);

        // Drain, then watch a little longer for stray results
        idle_on = 1'b1;
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("motion_projection_profile test passed");
        else
            $display("motion_projection_profile test failed");
        $finish;
    end

endmodule

[files.f]
rtl/mpp_pkg.sv
rtl/mpp_if.sv
rtl/mpp_front.sv
rtl/mpp_queue.sv
rtl/mpp_back.sv
rtl/motion_projection_profile.sv
test/mpp_checker.sv
test/tb_motion_projection_profile.sv
